### rtl/kabf_pkg.sv
// shared types, constants and helpers of the angle and bias kalman filter
`default_nettype none
package kabf_pkg;

  localparam int FracCov = 28;
  localparam int FracDt  = 24;

  localparam logic [31:0] AngleNoiseReset = 32'd4294967;
  localparam logic [31:0] BiasNoiseReset  = 32'd12884902;
  localparam logic [31:0] MeasNoiseReset  = 32'd128849019;

  localparam logic [1:0] RegAngleNoise = 2'd0;
  localparam logic [1:0] RegBiasNoise  = 2'd1;
  localparam logic [1:0] RegMeasNoise  = 2'd2;

  localparam logic OpUpdate   = 1'b0;
  localparam logic OpSetAngle = 1'b1;

  typedef struct packed {
    logic [0:0]  operation;
    logic [31:0] angle_in;
    logic [31:0] rate_in;
    logic [23:0] time_step;
  } req_t;

  typedef struct packed {
    logic [31:0] angle_out;
  } rsp_t;

  // divider handshake
  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [63:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quo;
  } div_rsp_t;

  function automatic logic [31:0] sat32(input logic signed [71:0] v);
    logic [31:0] r;
    if (v > 72'sd2147483647) r = 32'h7fff_ffff;
    else if (v < -72'sd2147483648) r = 32'h8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage
`default_nettype wire

### rtl/kabf_if.sv
// valid/ready channel carrying one payload
`default_nettype none
interface kabf_if #(parameter type T = logic) (input wire logic clk);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/kabf_div.sv
// restoring divider for the gains, one quotient bit a cycle, truncates toward zero
`default_nettype none
module kabf_div
  import kabf_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);
  logic [63:0] a;
  logic [63:0] b;
  logic [63:0] q;
  logic [64:0] rem;
  logic [6:0]  cnt;
  logic        busy;
  logic        neg;
  logic [64:0] trial;
  logic [63:0] qs;
  logic        done;
  logic [31:0] quo;

  assign trial = {rem[63:0], a[63]} - {1'b0, b};
  assign rsp = '{done: done, quo: quo};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        neg <= req.num[63] ^ req.den[63];
        a <= req.num[63] ? -req.num : req.num;
        b <= req.den[63] ? -req.den : req.den;
        rem <= '0;
        q <= '0;
        cnt <= 7'd0;
        busy <= 1'b1;
      end else if (busy) begin
        a <= {a[62:0], 1'b0};
        if (!trial[64]) begin
          rem <= trial;
          q <= {q[62:0], 1'b1};
        end else begin
          rem <= {rem[63:0], a[63]};
          q <= {q[62:0], 1'b0};
        end
        cnt <= cnt + 7'd1;
        if (cnt == 7'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // q holds the final magnitude while done is high
  always_comb begin
    qs = neg ? -q : q;
    if (!neg && q[63]) quo = 32'h7fff_ffff;
    else quo = sat32({{8{qs[63]}}, qs});
  end
endmodule
`default_nettype wire

### rtl/kabf_core.sv
// sequencer around one shared 33x33 multiplier
`default_nettype none
module kabf_core
  import kabf_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  kabf_if.sink        req_ch,
  kabf_if.source      rsp_ch
);
  localparam logic [4:0] S_IDLE = 5'd0,  S_RATE = 5'd1,  S_ANG  = 5'd2,
                         S_T    = 5'd3,  S_AA   = 5'd4,  S_AB   = 5'd5,
                         S_QB   = 5'd6,  S_DIV0 = 5'd7,  S_WT0  = 5'd8,
                         S_DIV1 = 5'd9,  S_WT1  = 5'd10, S_Y    = 5'd11,
                         S_CA   = 5'd12, S_CB   = 5'd13, S_C00  = 5'd14,
                         S_C01  = 5'd15, S_C10  = 5'd16, S_C11  = 5'd17,
                         S_OUT  = 5'd18, S_AL   = 5'd19, S_LAT1 = 5'd20,
                         S_AH   = 5'd21;

  logic [4:0]  state;
  logic [31:0] qa_reg, qb_reg, r_reg;
  logic [31:0] angle_est, bias_est, cov_aa, cov_ab, cov_ba, cov_bb;
  logic [31:0] p00, p01, rate, k0, k1, y, meas;
  logic [23:0] dt;
  logic signed [63:0] t;
  logic [31:0] out_reg;
  logic        out_valid;
  logic signed [34:0] inner;
  logic [65:0] acc;
  logic signed [71:0] dsum;

  // shared multiplier, operands carry a sign bit
  logic signed [32:0] ma, mb;
  logic signed [65:0] prod;
  assign prod = ma * mb;

  div_req_t dreq;
  div_rsp_t drsp;
  kabf_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  logic signed [63:0] s_wide;
  assign s_wide = $signed({{32{cov_aa[31]}}, cov_aa}) + $signed({36'd0, r_reg[31:4]});

  function automatic logic signed [71:0] fl(input logic signed [65:0] p, input int sh);
    logic signed [71:0] e;
    e = {{6{p[65]}}, p};
    return e >>> sh;
  endfunction

  function automatic logic signed [71:0] sx(input logic [31:0] v);
    return {{40{v[31]}}, v};
  endfunction

  always_comb begin
    ma = '0;
    mb = '0;
    case (state)
      S_ANG: begin ma = {9'd0, dt}; mb = {rate[31], rate}; end
      S_T: begin ma = {9'd0, dt}; mb = {cov_bb[31], cov_bb}; end
      S_AL: begin ma = {9'd0, dt}; mb = {17'd0, inner[15:0]}; end
      S_AH: begin ma = {9'd0, dt}; mb = {{14{inner[34]}}, inner[34:16]}; end
      S_QB: begin ma = {9'd0, dt}; mb = {1'b0, qb_reg}; end
      S_CA: begin ma = {k0[31], k0}; mb = {y[31], y}; end
      S_CB: begin ma = {k1[31], k1}; mb = {y[31], y}; end
      S_C00: begin ma = {k0[31], k0}; mb = {p00[31], p00}; end
      S_C01: begin ma = {k0[31], k0}; mb = {p01[31], p01}; end
      S_C10: begin ma = {k1[31], k1}; mb = {p00[31], p00}; end
      S_C11: begin ma = {k1[31], k1}; mb = {p01[31], p01}; end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  // dt times the prediction sum, split across the narrow multiplier
  assign dsum = ({{6{prod[65]}}, prod} <<< 16) + {6'd0, acc};

  assign req_ch.ready = (state == S_IDLE) && !out_valid;
  assign rsp_ch.valid = out_valid;
  assign rsp_ch.data.angle_out = out_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      qa_reg <= AngleNoiseReset;
      qb_reg <= BiasNoiseReset;
      r_reg <= MeasNoiseReset;
      angle_est <= '0; bias_est <= '0;
      cov_aa <= '0; cov_ab <= '0; cov_ba <= '0; cov_bb <= '0;
      dreq.start <= 1'b0;
    end else begin
      dreq.start <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          RegAngleNoise: qa_reg <= cfg_data;
          RegBiasNoise: qb_reg <= cfg_data;
          RegMeasNoise: r_reg <= cfg_data;
          default: ;
        endcase
      end
      if (rsp_ch.valid && rsp_ch.ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: if (req_ch.valid && req_ch.ready) begin
          meas <= req_ch.data.angle_in;
          dt <= req_ch.data.time_step;
          if (req_ch.data.operation == OpSetAngle) begin
            angle_est <= req_ch.data.angle_in;
            state <= S_OUT;
          end else begin
            rate <= req_ch.data.rate_in;
            state <= S_RATE;
          end
        end
        S_RATE: begin rate <= sat32(sx(rate) - sx(bias_est)); state <= S_ANG; end
        S_ANG: begin angle_est <= sat32(sx(angle_est) + fl(prod, FracDt)); state <= S_T; end
        S_T: begin
          t <= 64'(fl(prod, FracDt));
          state <= S_AA;
        end
        S_AA: begin
          inner <= 35'(t) - 35'($signed(cov_ab)) - 35'($signed(cov_ba))
                   + $signed({7'd0, qa_reg[31:4]});
          state <= S_AL;
        end
        S_AL: begin
          acc <= prod;
          state <= S_AH;
        end
        S_AH: begin
          cov_aa <= sat32(sx(cov_aa) + (dsum >>> FracDt));
          cov_ab <= sat32(sx(cov_ab) - 72'(t));
          cov_ba <= sat32(sx(cov_ba) - 72'(t));
          state <= S_QB;
        end
        S_QB: begin
          cov_bb <= sat32(sx(cov_bb) + fl(prod, FracCov));
          state <= S_DIV0;
        end
        S_DIV0: begin
          if (s_wide == '0) begin
            k0 <= '0; k1 <= '0; state <= S_Y;
          end else begin
            dreq.start <= 1'b1;
            dreq.num <= {{4{cov_aa[31]}}, cov_aa, 28'd0};
            dreq.den <= s_wide;
            state <= S_WT0;
          end
        end
        S_WT0: if (drsp.done) state <= S_LAT1;
        S_LAT1: begin
          k0 <= drsp.quo;
          dreq.start <= 1'b1;
          dreq.num <= {{4{cov_ba[31]}}, cov_ba, 28'd0};
          dreq.den <= s_wide;
          state <= S_DIV1;
        end
        S_DIV1: state <= S_WT1;
        S_WT1: if (drsp.done) state <= S_Y;
        S_Y: begin
          if (s_wide != '0) k1 <= drsp.quo;
          y <= sat32(sx(meas) - sx(angle_est));
          p00 <= cov_aa; p01 <= cov_ab;
          state <= S_CA;
        end
        S_CA: begin angle_est <= sat32(sx(angle_est) + fl(prod, FracCov)); state <= S_CB; end
        S_CB: begin bias_est <= sat32(sx(bias_est) + fl(prod, FracCov)); state <= S_C00; end
        S_C00: begin cov_aa <= sat32(sx(p00) - fl(prod, FracCov)); state <= S_C01; end
        S_C01: begin cov_ab <= sat32(sx(cov_ab) - fl(prod, FracCov)); state <= S_C10; end
        S_C10: begin cov_ba <= sat32(sx(cov_ba) - fl(prod, FracCov)); state <= S_C11; end
        S_C11: begin cov_bb <= sat32(sx(cov_bb) - fl(prod, FracCov)); state <= S_OUT; end
        S_OUT: if (!out_valid) begin
          out_reg <= angle_est;
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

### rtl/kalman_angle_bias_filter.sv
// Two-state angle and gyro bias kalman filter. An update request runs the sequencer
// steps on one shared 33x33 multiplier plus two 64-step gain divisions on the
// bit-serial divider. With a zero innovation variance the divisions are skipped.
// One request is in flight at a time; the result sits in an output register and the
// next request is taken once it leaves.
`default_nettype none
module kalman_angle_bias_filter
  import kabf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  kabf_if.sink             req_ch,
  kabf_if.source           rsp_ch
);
  kabf_core u_core (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .req_ch(req_ch), .rsp_ch(rsp_ch)
  );
endmodule
`default_nettype wire

### rtl/kabf_checker.sv
// port-level checks of the filter
`default_nettype none
module kabf_checker
  import kabf_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire logic req_valid,
  input wire logic req_ready,
  input wire logic rsp_valid,
  input wire logic rsp_ready,
  input wire logic [31:0] rsp_angle
);
  a_no_take_while_full: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !req_ready) else $error("request taken while result pending");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_angle))
    else $error("result dropped");
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready) else $error("ready while busy");
endmodule

bind kalman_angle_bias_filter kabf_checker u_chk (
  .clk(clk), .rst(rst), .req_valid(req_ch.valid), .req_ready(req_ch.ready),
  .rsp_valid(rsp_ch.valid), .rsp_ready(rsp_ch.ready), .rsp_angle(rsp_ch.data.angle_out)
);
`default_nettype wire

### tb/sv/kalman_angle_bias_filter_tb.sv
// self-checking testbench of the angle and gyro bias kalman filter
`default_nettype none
module kalman_angle_bias_filter_tb
  import kabf_pkg::*;
();

  // predicted filter state and expected angles
  class angle_scoreboard;
    logic [31:0] q_angle, q_bias, r_meas;
    longint angle_est, bias_est, p_aa, p_ab, p_ba, p_bb;
    logic [31:0] angle_fifo[$];
    int mismatches;

    function new();
      q_angle = AngleNoiseReset;
      q_bias = BiasNoiseReset;
      r_meas = MeasNoiseReset;
      angle_est = 0; bias_est = 0;
      p_aa = 0; p_ab = 0; p_ba = 0; p_bb = 0;
      mismatches = 0;
    endfunction

    function longint clip(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint gain_of(longint num, longint s);
      if (s == 0) return 0;
      return clip((num * (64'sd1 <<< FracCov)) / s);
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] v);
      if (idx == RegAngleNoise) q_angle = v;
      else if (idx == RegBiasNoise) q_bias = v;
      else if (idx == RegMeasNoise) r_meas = v;
    endfunction

    function void note_request(req_t rq);
      longint dt, rate, t, inner, s, k0, k1, y, a0, a1;
      longint unsigned qbdt;
      if (rq.operation == OpSetAngle) begin
        angle_est = longint'($signed(rq.angle_in));
      end else begin
        dt = longint'({40'd0, rq.time_step});
        qbdt = (longint'({32'd0, q_bias}) * dt) >> FracCov;
        rate = clip(longint'($signed(rq.rate_in)) - bias_est);
        angle_est = clip(angle_est + ((dt * rate) >>> FracDt));
        t = (dt * p_bb) >>> FracDt;
        inner = t - p_ab - p_ba + longint'({36'd0, q_angle[31:4]});
        p_aa = clip(p_aa + ((dt * inner) >>> FracDt));
        p_ab = clip(p_ab - t);
        p_ba = clip(p_ba - t);
        p_bb = clip(p_bb + longint'(qbdt));
        s = p_aa + longint'({36'd0, r_meas[31:4]});
        k0 = gain_of(p_aa, s);
        k1 = gain_of(p_ba, s);
        y = clip(longint'($signed(rq.angle_in)) - angle_est);
        angle_est = clip(angle_est + ((k0 * y) >>> FracCov));
        bias_est = clip(bias_est + ((k1 * y) >>> FracCov));
        a0 = p_aa; a1 = p_ab;
        p_aa = clip(a0 - ((k0 * a0) >>> FracCov));
        p_ab = clip(a1 - ((k0 * a1) >>> FracCov));
        p_ba = clip(p_ba - ((k1 * a0) >>> FracCov));
        p_bb = clip(p_bb - ((k1 * a1) >>> FracCov));
      end
      angle_fifo.push_back(angle_est[31:0]);
    endfunction

    function void check_angle(rsp_t rs);
      logic [31:0] want;
      if (angle_fifo.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected angle_out %h", rs.angle_out);
        return;
      end
      want = angle_fifo.pop_front();
      if (rs.angle_out !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("angle_out mismatch: expected %h actual %h", want, rs.angle_out);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  kabf_if #(.T(req_t)) req_ch (clk);
  kabf_if #(.T(rsp_t)) rsp_ch (clk);

  angle_scoreboard sb = new();
  int cycles = 0;
  int hold_off = 0;
  int rsp_wait = 0;
  int rsp_draw;

  localparam int CycleLimit = 400000;

  kalman_angle_bias_filter dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    rsp_ch.ready = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // receiver: drawn wait per result, plus a long hold-off on demand
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready) sb.check_angle(rsp_ch.data);
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        rsp_ch.ready <= 1'b0;
      end else if (rsp_ch.valid && rsp_ch.ready) begin
        rsp_draw = $urandom_range(0, 16);
        rsp_wait <= rsp_draw;
        rsp_ch.ready <= (rsp_draw == 0);
      end else if (rsp_wait > 0) begin
        rsp_wait <= rsp_wait - 1;
        rsp_ch.ready <= (rsp_wait == 1);
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_request(logic op, logic [31:0] ang, logic [31:0] rate,
                              logic [23:0] dt);
    int gap;
    gap = $urandom_range(0, 16);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data <= '{operation: op, angle_in: ang, rate_in: rate, time_step: dt};
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sb.note_request(req_ch.data);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, v);
    @(posedge clk);
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    while (sb.angle_fifo.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic random_request();
    logic [31:0] ang, rate;
    logic [23:0] dt;
    ang = $urandom_range(0, 7) == 0 ? $urandom() : $signed($urandom_range(0, 2 * 655360)) - 655360;
    rate = $urandom_range(0, 7) == 0 ? $urandom() : $signed($urandom_range(0, 2 * 6553600)) - 6553600;
    dt = 24'($urandom_range(0, 7) == 0 ? $urandom() : $urandom_range(0, 400000));
    send_request($urandom_range(0, 9) == 0 ? OpSetAngle : OpUpdate, ang, rate, dt);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, both operations, zero innovation variance
    write_reg(RegAngleNoise, 32'd0);
    write_reg(RegMeasNoise, 32'd0);
    send_request(OpUpdate, 32'd65536, 32'd0, 24'd0);
    drain();
    write_reg(RegAngleNoise, AngleNoiseReset);
    write_reg(RegMeasNoise, MeasNoiseReset);
    send_request(OpSetAngle, 32'h7fff_ffff, 32'hffff_ffff, 24'hff_ffff);
    send_request(OpUpdate, 32'h8000_0000, 32'h7fff_ffff, 24'hff_ffff);
    send_request(OpUpdate, 32'h7fff_ffff, 32'h8000_0000, 24'hff_ffff);
    send_request(OpSetAngle, 32'h8000_0000, 32'd0, 24'd0);
    send_request(OpUpdate, 32'h7fff_ffff, 32'h7fff_ffff, 24'hff_ffff);
    send_request(OpUpdate, 32'd0, 32'd0, 24'd1);
    send_request(OpSetAngle, 32'd0, 32'd0, 24'd0);
    for (int i = 0; i < 8; i++) send_request(OpUpdate, 32'd655360, 32'd65536, 24'd16777);
    drain();
    write_reg(RegAngleNoise, 32'hffff_ffff);
    write_reg(RegBiasNoise, 32'hffff_ffff);
    write_reg(RegMeasNoise, 32'hffff_ffff);
    for (int i = 0; i < 5; i++) random_request();
    drain();

    // random phases under several noise settings
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(RegAngleNoise, ph == 0 ? AngleNoiseReset : $urandom());
      write_reg(RegBiasNoise, ph == 0 ? BiasNoiseReset : $urandom_range(0, 1 << 26));
      write_reg(RegMeasNoise, ph == 4 ? 32'd0 : $urandom());
      if (ph == 2) begin
        // long receiver stall while requests keep coming
        hold_off = 600;
      end
      for (int i = 0; i < 85; i++) random_request();
      drain();
    end

    if (sb.mismatches == 0 && sb.angle_fifo.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
`default_nettype wire

### files.f
rtl/kabf_pkg.sv
rtl/kabf_if.sv
rtl/kabf_div.sv
rtl/kabf_core.sv
rtl/kalman_angle_bias_filter.sv
rtl/kabf_checker.sv
tb/sv/kalman_angle_bias_filter_tb.sv
